// File: sv/dhse_pkg.sv
// ---------------------------------------------------------------------------
// dhse_pkg
// shared constants and codes for the double-hashed key set engine
// ---------------------------------------------------------------------------
package dhse_pkg;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;

  localparam int KEY_PORT_W   = 32;
  localparam int HASH_PORT_W  = 32;
  localparam int SLOT_PORT_W  = 6;
  localparam int COUNT_PORT_W = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] SS_EMPTY = 2'd0;
  localparam logic [1:0] SS_LIVE  = 2'd1;
  localparam logic [1:0] SS_TOMB  = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_EXHAUSTED = 2'd2;

endpackage

// File: sv/double_hash_set_engine_core.sv
// ---------------------------------------------------------------------------
// double_hash_set_engine_core
// open-addressed key set with double hashing over a power-of-two slot table
// ---------------------------------------------------------------------------
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_operation, in_key, in_key_hash
// out     | output    | out_valid, out_ready, out_status, out_slot, out_entry_count
//
// the step modulo (TABLE_SLOTS-1) folds one hash digit per cycle in one adder
// probes read the slot ram once per cycle through its single read port
// after reset a clearing pass over all TABLE_SLOTS slots empties the table, in_ready low
// a stalled result holds the engine in its result cycle
// ---------------------------------------------------------------------------
module double_hash_set_engine_core
  import dhse_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic [KEY_PORT_W-1:0]   in_key,
  input  logic [HASH_PORT_W-1:0]  in_key_hash,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [SLOT_PORT_W-1:0]  out_slot,
  output logic [COUNT_PORT_W-1:0] out_entry_count
);

  localparam int SW     = $clog2(TABLE_SLOTS);
  localparam int CW     = $clog2(TABLE_SLOTS + 1);
  localparam int SKB    = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int DIGITS = (HASH_PORT_W + SW - 1) / SW;
  localparam int HX     = DIGITS * SW;
  localparam int DCW    = $clog2(DIGITS);
  localparam int RW     = 2 + SKB;
  localparam int MOD_M  = TABLE_SLOTS - 1;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [1:0]              op_r, op_nxt;
  logic [SKB-1:0]          key_r, key_nxt;
  logic [HX-1:0]           h_r, h_nxt;
  logic [DCW-1:0]          dig_r, dig_nxt;
  logic [SW-1:0]           acc_r, acc_nxt;
  logic [SW-1:0]           step_r, step_nxt;
  logic [SW-1:0]           pos_r, pos_nxt;
  logic [SW-1:0]           prb_r, prb_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [1:0]              res_status_r, res_status_nxt;
  logic [SW-1:0]           res_slot_r, res_slot_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic [SLOT_PORT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [COUNT_PORT_W-1:0] out_count_r, out_count_nxt;

  logic [SW:0]     fold_sum;
  logic [SW:0]     fold_red;
  logic            ram_we;
  logic [SW-1:0]   ram_waddr;
  logic [RW-1:0]   ram_wdata;
  logic [SW-1:0]   ram_raddr;
  logic [RW-1:0]   ram_rdata;
  logic [1:0]      rd_state;
  logic [SKB-1:0]  rd_key;
  logic            rd_live;
  logic            rd_match;
  logic [SKB-1:0]  in_key_m;
  logic [31:0]     slot_ext;
  logic [31:0]     cnt_ext;

  dhse_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_key_m = in_key[SKB-1:0];
  assign rd_state = ram_rdata[RW-1:SKB];
  assign rd_key   = ram_rdata[SKB-1:0];
  assign rd_live  = (rd_state == SS_LIVE);
  assign rd_match = rd_live && (rd_key == key_r);

  // digit fold: 2^SW is 1 mod (TABLE_SLOTS-1)
  assign fold_sum = {1'b0, acc_r} + {1'b0, h_r[SW-1:0]};
  assign fold_red = (fold_sum >= (SW+1)'(MOD_M)) ? (fold_sum - (SW+1)'(MOD_M)) : fold_sum;

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_entry_count = out_count_r;

  assign slot_ext = 32'(res_slot_r);
  assign cnt_ext  = 32'(cnt_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    h_nxt          = h_r;
    dig_nxt        = dig_r;
    acc_nxt        = acc_r;
    step_nxt       = step_r;
    pos_nxt        = pos_r;
    prb_nxt        = prb_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = {SS_EMPTY, SKB'(0)};
    ram_raddr      = pos_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        if (pos_r == SW'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_r + SW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_operation;
          key_nxt = in_key_m;
          h_nxt   = HX'(in_key_hash);
          dig_nxt = DCW'(DIGITS - 1);
          acc_nxt = '0;
          pos_nxt = in_key_hash[SW-1:0];
          prb_nxt = '0;
          if (in_operation == OP_INSERT || in_operation == OP_LOOKUP ||
              in_operation == OP_REMOVE) begin
            if (in_key_m != '0) begin
              state_nxt = S_HASH;
            end else begin
              res_status_nxt = STS_NOT_FOUND;
              res_slot_nxt   = '0;
              state_nxt      = S_FIN;
            end
          end else begin
            res_status_nxt = STS_NOT_FOUND;
            res_slot_nxt   = '0;
            state_nxt      = S_FIN;
          end
        end
      end
      S_HASH: begin
        acc_nxt = fold_red[SW-1:0];
        h_nxt   = h_r >> SW;
        dig_nxt = dig_r - DCW'(1);
        if (dig_r == '0) begin
          step_nxt  = fold_red[SW-1:0] | SW'(1);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ram_raddr = pos_r + step_r;
        if (op_r == OP_INSERT && (!rd_live || rd_match)) begin
          ram_we    = 1'b1;
          ram_wdata = {SS_LIVE, key_r};
          if (!rd_match) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          res_status_nxt = STS_OK;
          res_slot_nxt   = pos_r;
          state_nxt      = S_FIN;
        end else if (op_r != OP_INSERT && rd_state == SS_EMPTY) begin
          res_status_nxt = STS_NOT_FOUND;
          res_slot_nxt   = pos_r;
          state_nxt      = S_FIN;
        end else if (op_r != OP_INSERT && rd_match) begin
          if (op_r == OP_REMOVE) begin
            ram_we    = 1'b1;
            ram_wdata = {SS_TOMB, SKB'(0)};
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end
          res_status_nxt = STS_OK;
          res_slot_nxt   = pos_r;
          state_nxt      = S_FIN;
        end else if (prb_r == SW'(TABLE_SLOTS - 1)) begin
          res_status_nxt = STS_EXHAUSTED;
          res_slot_nxt   = pos_r;
          state_nxt      = S_FIN;
        end else begin
          prb_nxt = prb_r + SW'(1);
          pos_nxt = pos_r + step_r;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = slot_ext[SLOT_PORT_W-1:0];
          out_count_nxt  = cnt_ext[COUNT_PORT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    h_r          <= h_nxt;
    dig_r        <= dig_nxt;
    acc_r        <= acc_nxt;
    step_r       <= step_nxt;
    prb_r        <= prb_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_SLOTS))
    else $error("live count above table size");

  a_step_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> step_r[0])
    else $error("probe step is even");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR || state_r == S_CHECK))
    else $error("slot write outside clear or probe");

  a_count_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |-> $past(ram_we))
    else $error("live count changed without a slot write");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!in_ready && ram_we))
    else $error("accepting word during clearing pass");

endmodule

// File: sv/dhse_ram.sv
// ---------------------------------------------------------------------------
// dhse_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module dhse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: bench/double_hash_set_engine_core_test.sv
// ---------------------------------------------------------------------------
// double_hash_set_engine_core_test
// self-checking bench for the double-hashed key set engine: a directed
// opening, then pools of keys with fixed hashes filled and drained in
// growing epochs until the table saturates, with random gaps and stalls on
// both channels and every result checked against an in-bench set model
// ---------------------------------------------------------------------------
module double_hash_set_engine_core_test
  import dhse_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 100;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_PORT_W-1:0]  slot;
    logic [COUNT_PORT_W-1:0] count;
  } outcome_t;

  class key_set_board;
    logic [KEY_PORT_W-1:0] key_at [TABLE_SLOTS_DEF];
    logic [1:0]            state_at [TABLE_SLOTS_DEF];
    int unsigned           live_n;
    outcome_t              awaited [$];
    int unsigned           errors;

    function new();
      foreach (state_at[s]) begin
        state_at[s] = SS_EMPTY;
        key_at[s]   = '0;
      end
      live_n = 0;
      errors = 0;
    endfunction

    function void note_word(logic [1:0] op, logic [KEY_PORT_W-1:0] key,
                            logic [HASH_PORT_W-1:0] hash);
      outcome_t    e;
      int unsigned home, stride, spot;
      bit          hit;
      e.status = STS_NOT_FOUND;
      e.slot   = '0;
      if (op != OP_UNUSED && key != '0) begin
        e.status = STS_EXHAUSTED;
        home   = hash % TABLE_SLOTS_DEF;
        stride = hash % (TABLE_SLOTS_DEF - 1);
        if (stride % 2 == 0) stride++;
        for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
          spot   = (home + i * stride) % TABLE_SLOTS_DEF;
          hit    = (state_at[spot] == SS_LIVE) && (key_at[spot] == key);
          e.slot = SLOT_PORT_W'(spot);
          if (op == OP_INSERT) begin
            if (state_at[spot] != SS_LIVE || hit) begin
              if (!hit) live_n++;
              key_at[spot]   = key;
              state_at[spot] = SS_LIVE;
              e.status       = STS_OK;
              break;
            end
          end else if (state_at[spot] == SS_EMPTY) begin
            e.status = STS_NOT_FOUND;
            break;
          end else if (hit) begin
            if (op == OP_REMOVE) begin
              state_at[spot] = SS_TOMB;
              key_at[spot]   = '0;
              if (live_n > 0) live_n--;
            end
            e.status = STS_OK;
            break;
          end
        end
      end
      e.count = COUNT_PORT_W'(live_n);
      awaited.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %0d, want %0d", what, got, want);
      errors++;
    endtask

    task check_word(logic [1:0] status, logic [SLOT_PORT_W-1:0] slot,
                    logic [COUNT_PORT_W-1:0] count);
      outcome_t want;
      if (awaited.size() == 0) begin
        report("unexpected word status", 32'(status), 32'(STS_OK));
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status) report("status", 32'(status), 32'(want.status));
      if (slot !== want.slot) report("slot", 32'(slot), 32'(want.slot));
      if (count !== want.count) report("entry count", 32'(count), 32'(want.count));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_operation = OP_INSERT;
  logic [KEY_PORT_W-1:0]   in_key = '0;
  logic [HASH_PORT_W-1:0]  in_key_hash = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_status;
  logic [SLOT_PORT_W-1:0]  out_slot;
  logic [COUNT_PORT_W-1:0] out_entry_count;

  key_set_board sb;
  bit           rush = 1'b0;
  int unsigned  cycle_n = 0;

  double_hash_set_engine_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_key_hash     (in_key_hash),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    if (rush) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [KEY_PORT_W-1:0] rand_key();
    logic [KEY_PORT_W-1:0] k;
    k = $urandom;
    if (k == '0) k = 1;
    return k;
  endfunction

  function automatic logic [HASH_PORT_W-1:0] rand_hash();
    logic [HASH_PORT_W-1:0] h;
    h = $urandom;
    // crowd some home slots so probe chains grow
    if ($urandom_range(0, 1) == 1) h[5:0] = 6'($urandom_range(0, 3));
    return h;
  endfunction

  task automatic send_word(logic [1:0] op, logic [KEY_PORT_W-1:0] key,
                           logic [HASH_PORT_W-1:0] hash);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    in_key_hash  <= hash;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_word(op, key, hash);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    while (cycle_n < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_n++;
    end
    $display("simulation failed");
    $finish;
  end

  // result side
  initial begin
    int got;
    int pause;
    got = 0;
    wait (rst_n === 1'b1);
    forever begin
      pause = (got == 150 || got == 900) ? LONG_HOLD : draw_gap();
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_word(out_status, out_slot, out_entry_count);
      got++;
    end
  end

  initial begin
    int                     pool_sizes [6];
    logic [KEY_PORT_W-1:0]  pool_key [$];
    logic [HASH_PORT_W-1:0] pool_hash [$];
    logic [KEY_PORT_W-1:0]  k;
    logic [HASH_PORT_W-1:0] h;
    logic [1:0]             op;
    int                     sent, pick, roll, roll2, phase_len;
    pool_sizes = '{8, 16, 28, 44, 72, 96};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_LOOKUP, 32'd5, 32'd0);
    send_word(OP_REMOVE, 32'd5, 32'd0);
    send_word(OP_INSERT, 32'd1, 32'd0);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'd1, 32'd0);
    send_word(OP_INSERT, 32'd2, 32'd0);
    send_word(OP_INSERT, 32'd3, 32'd0);
    send_word(OP_REMOVE, 32'd2, 32'd0);
    send_word(OP_LOOKUP, 32'd3, 32'd0);
    // tombstone ahead of a live copy gets reused
    send_word(OP_INSERT, 32'd3, 32'd0);
    send_word(OP_REMOVE, 32'd3, 32'd0);
    send_word(OP_LOOKUP, 32'd3, 32'd0);
    send_word(OP_LOOKUP, 32'd9, 32'd0);
    send_word(OP_INSERT, 32'd0, 32'h1234_5678);
    send_word(OP_LOOKUP, 32'd0, 32'd0);
    send_word(OP_UNUSED, 32'd7, 32'd0);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h8000_0001, 32'h0000_003F);
    send_word(OP_INSERT, 32'h7FFF_FFFE, 32'h0000_003F);
    send_word(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_REMOVE, 32'h8000_0001, 32'h0000_003F);
    wait_for_results();

    foreach (pool_sizes[ep]) begin
      pool_key.delete();
      pool_hash.delete();
      repeat (pool_sizes[ep]) begin
        pool_key.push_back(rand_key());
        pool_hash.push_back(rand_hash());
      end
      phase_len = 2 * pool_sizes[ep];
      sent = 0;
      while (sent < 2 * phase_len) begin
        if (sent % 40 == 0) rush = ($urandom_range(0, 3) == 0);
        pick  = $urandom_range(0, pool_key.size() - 1);
        k     = pool_key[pick];
        h     = pool_hash[pick];
        roll  = $urandom_range(0, 99);
        roll2 = $urandom_range(0, 99);
        if (roll < 2) begin
          send_word(2'($urandom_range(0, 3)), '0, $urandom);
        end else if (roll < 4) begin
          send_word(OP_UNUSED, rand_key(), $urandom);
        end else begin
          // strangers and stray hashes only probe, never insert
          if (roll < 8) k = rand_key();
          else if (roll < 12) h = $urandom;
          if (roll < 12) op = (roll2 < 50) ? OP_LOOKUP : OP_REMOVE;
          else if (sent < phase_len) begin
            op = (roll2 < 75) ? OP_INSERT : (roll2 < 90) ? OP_LOOKUP : OP_REMOVE;
          end else begin
            op = (roll2 < 15) ? OP_INSERT : (roll2 < 40) ? OP_LOOKUP : OP_REMOVE;
          end
          send_word(op, k, h);
          sent++;
        end
      end
      rush = 1'b0;
      foreach (pool_key[i]) send_word(OP_REMOVE, pool_key[i], pool_hash[i]);
      wait_for_results();
    end

    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
